// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define CCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compass heading assertion failed");

// Next-cycle implication, live during reset too.
`define CCH_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("compass heading assertion failed");

`endif

// File: hw/rtl/cch_pkg.sv
// Package for the calibrated compass heading block: widths, register
// indexes, reset values, arctangent table and the pipeline control struct.
// No dependencies.
`default_nettype none

package cch_pkg;

    localparam int CAL_W     = 16;           // calibration and raw sample width
    localparam int CX_W      = CAL_W + 2;    // 2*raw - (min + max)
    localparam int SPAN_W    = CAL_W + 1;    // max - min
    localparam int PW        = CX_W + SPAN_W; // cross product
    localparam int NW        = 41;           // normalized magnitude, top bit 2^40
    localparam int DW        = 45;           // rotation datapath, room for CORDIC gain
    localparam int PH_W      = 32;           // phase, 2^-32 turn
    localparam int DEG_W     = 9;
    localparam int PROD_W    = PH_W + DEG_W;
    localparam int CFG_IDX_W = 8;

    localparam int CORDIC_STAGES_DEF = 20;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = CFG_IDX_W'(3);

    localparam logic signed [CAL_W-1:0] MIN_X_RST = 16'sd1087;
    localparam logic signed [CAL_W-1:0] MAX_X_RST = 16'sd1621;
    localparam logic signed [CAL_W-1:0] MIN_Y_RST = 16'sd1912;
    localparam logic signed [CAL_W-1:0] MAX_Y_RST = 16'sd2417;

    localparam logic [DEG_W-1:0] DEG_0   = 9'd0;
    localparam logic [DEG_W-1:0] DEG_45  = 9'd45;
    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_135 = 9'd135;
    localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
    localparam logic [DEG_W-1:0] DEG_225 = 9'd225;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_315 = 9'd315;

    localparam logic [PH_W-1:0] DEG_PER_TURN = PH_W'(360);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [PH_W-1:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic             vld;
        logic             spec;      // heading known without rotation
        logic [DEG_W-1:0] spec_deg;
        logic             cal_err;
    } t_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/cch_cordic_stage.sv
// One registered vectoring micro-rotation of the heading CORDIC.
// Depends on cch_pkg.
`default_nettype none

module cch_cordic_stage
    import cch_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl                 i_ctl,
    input  wire logic signed [DW-1:0] i_x,
    input  wire logic signed [DW-1:0] i_y,
    input  wire logic [PH_W-1:0]      i_phase,
    output t_ctl                      o_ctl,
    output logic signed [DW-1:0]      o_x,
    output logic signed [DW-1:0]      o_y,
    output logic [PH_W-1:0]           o_phase
);

    localparam logic [PH_W-1:0] ATAN = ATAN_TURNS[IDX];

    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;

    assign w_dx = i_y >>> IDX;
    assign w_dy = i_x >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        if (!i_y[DW-1]) begin
            o_x     <= i_x + w_dx;
            o_y     <= i_y - w_dy;
            o_phase <= i_phase + ATAN;
        end else begin
            o_x     <= i_x - w_dx;
            o_y     <= i_y + w_dy;
            o_phase <= i_phase - ATAN;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/calibrated_compass_heading.sv
// Calibrated compass heading: hard-iron centering, cross-multiplied
// scaling, normalization and a pipelined CORDIC atan2 in whole degrees.
// Depends on cch_pkg and cch_cordic_stage.
//
//   channel   signals                                      handshake
//   input     i_start, o_busy, i_raw_x, i_raw_y            start & !busy
//   result    o_valid, o_heading_deg, o_cal_error          one-cycle strobe
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index/data   valid & ready
//
// Throughput: one item per clock outside reset, any mix of items and idle cycles.
// Pipeline: registered stages A to E, the micro-rotation chain with
// one register stage per CORDIC iteration, then the output register.
// Reset is synchronous; busy stays high and cfg_ready low through the cycle after.
// Nothing stalls: every stage advances every clock.
`default_nettype none

module calibrated_compass_heading
    import cch_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    output logic                         o_busy,
    input  wire logic signed [CAL_W-1:0] i_raw_x,
    input  wire logic signed [CAL_W-1:0] i_raw_y,
    output logic                         o_valid,
    output logic [DEG_W-1:0]             o_heading_deg,
    output logic                         o_cal_error,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CAL_W-1:0]        i_cfg_data
);

    logic signed [CAL_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;

    // stage A: centering
    logic signed [SPAN_W-1:0] w_span_x, w_span_y, w_sum_x, w_sum_y;
    logic signed [CX_W-1:0]   w_cx2, w_cy2;
    logic                     w_err;
    t_ctl                     r_a_ctl;
    logic signed [CX_W-1:0]   r_a_cx2, r_a_cy2;
    logic signed [SPAN_W-1:0] r_a_span_x, r_a_span_y;

    // stage B: cross products
    t_ctl                 r_b_ctl;
    logic signed [PW-1:0] r_b_x, r_b_y;

    // stage C: special cases, half-turn fold, magnitude
    logic signed [PW-1:0] w_ax, w_ay;
    t_ctl                 n_c_ctl;
    t_ctl                 r_c_ctl;
    logic signed [PW-1:0] r_c_x, r_c_y;
    logic [NW-1:0]        r_c_m;
    logic                 r_c_half;

    // stages D and E: normalize to [2^40, 2^41)
    logic [NW-1:0]        w_d_m;
    logic signed [DW-1:0] w_d_x, w_d_y;
    t_ctl                 r_d_ctl;
    logic signed [DW-1:0] r_d_x, r_d_y;
    logic [NW-1:0]        r_d_m;
    logic                 r_d_half;

    logic [NW-1:0]        w_e_m;
    logic signed [DW-1:0] w_e_x, w_e_y;
    t_ctl                 r_e_ctl;
    logic signed [DW-1:0] r_e_x, r_e_y;
    logic                 r_e_half;

    // rotation chain
    t_ctl                 w_ctl   [0:CORDIC_STAGES];
    logic signed [DW-1:0] w_x     [0:CORDIC_STAGES];
    logic signed [DW-1:0] w_y     [0:CORDIC_STAGES];
    logic [PH_W-1:0]      w_phase [0:CORDIC_STAGES];

    logic [PROD_W-1:0] w_prod;
    t_ctl              w_last;

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy      <= 1'b1;
            o_cfg_ready <= 1'b0;
            r_min_x     <= MIN_X_RST;
            r_max_x     <= MAX_X_RST;
            r_min_y     <= MIN_Y_RST;
            r_max_y     <= MAX_Y_RST;
        end else begin
            o_busy      <= 1'b0;
            o_cfg_ready <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MIN_X: r_min_x <= i_cfg_data;
                    REG_MAX_X: r_max_x <= i_cfg_data;
                    REG_MIN_Y: r_min_y <= i_cfg_data;
                    REG_MAX_Y: r_max_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- stage A
    assign w_span_x = SPAN_W'(r_max_x) - SPAN_W'(r_min_x);
    assign w_span_y = SPAN_W'(r_max_y) - SPAN_W'(r_min_y);
    assign w_sum_x  = SPAN_W'(r_max_x) + SPAN_W'(r_min_x);
    assign w_sum_y  = SPAN_W'(r_max_y) + SPAN_W'(r_min_y);
    assign w_cx2    = (CX_W'(i_raw_x) <<< 1) - CX_W'(w_sum_x);
    assign w_cy2    = (CX_W'(i_raw_y) <<< 1) - CX_W'(w_sum_y);
    assign w_err    = w_span_x[SPAN_W-1] || (w_span_x == '0)
                   || w_span_y[SPAN_W-1] || (w_span_y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl.vld      <= i_start && !o_busy;
            r_a_ctl.spec     <= w_err;
            r_a_ctl.spec_deg <= DEG_0;
            r_a_ctl.cal_err  <= w_err;
        end
        r_a_cx2    <= w_cx2;
        r_a_cy2    <= w_cy2;
        r_a_span_x <= w_span_x;
        r_a_span_y <= w_span_y;
    end

    // ---------------------------------------------------------------- stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= r_a_ctl;
        end
        r_b_x <= PW'(r_a_cx2) * PW'(r_a_span_y);
        r_b_y <= PW'(r_a_cy2) * PW'(r_a_span_x);
    end

    // ---------------------------------------------------------------- stage C
    assign w_ax = r_b_x[PW-1] ? -r_b_x : r_b_x;
    assign w_ay = r_b_y[PW-1] ? -r_b_y : r_b_y;

    always_comb begin
        n_c_ctl = r_b_ctl;
        if (!r_b_ctl.cal_err) begin
            n_c_ctl.spec = 1'b1;
            if (r_b_y == '0) begin
                n_c_ctl.spec_deg = r_b_x[PW-1] ? DEG_180 : DEG_0;
            end else if (r_b_x == '0) begin
                n_c_ctl.spec_deg = r_b_y[PW-1] ? DEG_270 : DEG_90;
            end else if (w_ax == w_ay) begin
                if (!r_b_x[PW-1]) begin
                    n_c_ctl.spec_deg = r_b_y[PW-1] ? DEG_315 : DEG_45;
                end else begin
                    n_c_ctl.spec_deg = r_b_y[PW-1] ? DEG_225 : DEG_135;
                end
            end else begin
                n_c_ctl.spec = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= n_c_ctl;
        end
        r_c_half <= r_b_x[PW-1];
        r_c_x    <= r_b_x[PW-1] ? -r_b_x : r_b_x;
        r_c_y    <= r_b_x[PW-1] ? -r_b_y : r_b_y;
        r_c_m    <= NW'($unsigned((w_ax > w_ay) ? w_ax : w_ay));
    end

    // ---------------------------------------------------------------- stage D
    always_comb begin
        w_d_m = r_c_m;
        w_d_x = DW'(r_c_x);
        w_d_y = DW'(r_c_y);
        if (w_d_m[NW-1:NW-32] == '0) begin
            w_d_m = w_d_m << 32;
            w_d_x = w_d_x <<< 32;
            w_d_y = w_d_y <<< 32;
        end
        if (w_d_m[NW-1:NW-16] == '0) begin
            w_d_m = w_d_m << 16;
            w_d_x = w_d_x <<< 16;
            w_d_y = w_d_y <<< 16;
        end
        if (w_d_m[NW-1:NW-8] == '0) begin
            w_d_m = w_d_m << 8;
            w_d_x = w_d_x <<< 8;
            w_d_y = w_d_y <<< 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl <= r_c_ctl;
        end
        r_d_m    <= w_d_m;
        r_d_x    <= w_d_x;
        r_d_y    <= w_d_y;
        r_d_half <= r_c_half;
    end

    // ---------------------------------------------------------------- stage E
    always_comb begin
        w_e_m = r_d_m;
        w_e_x = r_d_x;
        w_e_y = r_d_y;
        if (w_e_m[NW-1:NW-4] == '0) begin
            w_e_m = w_e_m << 4;
            w_e_x = w_e_x <<< 4;
            w_e_y = w_e_y <<< 4;
        end
        if (w_e_m[NW-1:NW-2] == '0) begin
            w_e_m = w_e_m << 2;
            w_e_x = w_e_x <<< 2;
            w_e_y = w_e_y <<< 2;
        end
        if (!w_e_m[NW-1]) begin
            w_e_x = w_e_x <<< 1;
            w_e_y = w_e_y <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl <= '0;
        end else begin
            r_e_ctl <= r_d_ctl;
        end
        r_e_x    <= w_e_x;
        r_e_y    <= w_e_y;
        r_e_half <= r_d_half;
    end

    // ---------------------------------------------------------------- CORDIC
    assign w_ctl[0]   = r_e_ctl;
    assign w_x[0]     = r_e_x;
    assign w_y[0]     = r_e_y;
    assign w_phase[0] = {r_e_half, {(PH_W-1){1'b0}}};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        cch_cordic_stage #(
            .IDX (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_phase (w_phase[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_phase (w_phase[g+1])
        );
    end

    // ---------------------------------------------------------------- output
    assign w_last = w_ctl[CORDIC_STAGES];
    assign w_prod = PROD_W'(w_phase[CORDIC_STAGES]) * PROD_W'(DEG_PER_TURN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last.vld;
        end
        o_cal_error   <= w_last.cal_err;
        o_heading_deg <= w_last.spec ? w_last.spec_deg : w_prod[PROD_W-1:PH_W];
    end

endmodule

`default_nettype wire

// File: hw/rtl/cch_checker.sv
// Port-level checker for the calibrated compass heading block, with its bind.
// Depends on cch_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cch_checker
    import cch_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic             i_busy,
    input wire logic             i_valid,
    input wire logic [DEG_W-1:0] i_heading_deg,
    input wire logic             i_cal_error,
    input wire logic             i_cfg_ready
);

    localparam int LAT = CORDIC_STAGES + 6;

    `CCH_ASSERT_IMP(a_result_has_item, i_clk, i_rst_n, i_valid, $past(i_start && !i_busy, LAT))
    `CCH_ASSERT_IMP(a_cal_err_zero, i_clk, i_rst_n, i_valid && i_cal_error, i_heading_deg == DEG_0)
    `CCH_ASSERT_IMP(a_heading_range, i_clk, i_rst_n, i_valid, i_heading_deg <= 9'd359)
    `CCH_ASSERT_NXT(a_reset_quiet, i_clk, !i_rst_n, i_busy && !i_valid && !i_cfg_ready)

endmodule

bind calibrated_compass_heading cch_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_cch_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .i_busy        (o_busy),
    .i_valid       (o_valid),
    .i_heading_deg (o_heading_deg),
    .i_cal_error   (o_cal_error),
    .i_cfg_ready   (o_cfg_ready)
);

`default_nettype wire

// File: tb/calibrated_compass_heading_test.sv
`timescale 1ns / 100ps
// Testbench for calibrated_compass_heading: random and directed samples over several
// calibrations, checked against an in-bench CORDIC heading predictor. Depends on cch_pkg.

module calibrated_compass_heading_test;
    import cch_pkg::*;

    localparam int N_ROT = 20;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ROT_ANGLE [0:N_ROT-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
    };

    typedef struct packed {
        logic signed [CAL_W-1:0] x;
        logic signed [CAL_W-1:0] y;
    } t_sample;

    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic             cal_err;
    } t_heading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic signed [CAL_W-1:0] i_raw_x = '0;
    logic signed [CAL_W-1:0] i_raw_y = '0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CAL_W-1:0]        i_cfg_data = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic [DEG_W-1:0]        o_heading_deg;
    logic                    o_cal_error;
    logic                    o_cfg_ready;

    logic signed [CAL_W-1:0] cal_min_x = MIN_X_RST;
    logic signed [CAL_W-1:0] cal_max_x = MAX_X_RST;
    logic signed [CAL_W-1:0] cal_min_y = MIN_Y_RST;
    logic signed [CAL_W-1:0] cal_max_y = MAX_Y_RST;

    t_sample  pending_samples[$];
    t_heading expected_headings[$];
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    int       burst_left = 1;
    int       gap_left = 0;

    calibrated_compass_heading #(
        .CORDIC_STAGES(N_ROT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .o_valid      (o_valid),
        .o_heading_deg(o_heading_deg),
        .o_cal_error  (o_cal_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [DEG_W-1:0] vector_angle_deg(longint vx, longint vy);
        logic [31:0] phase;
        logic [63:0] scaled;
        longint      ax, ay, m, dx, dy;
        int          i;
        phase = '0;
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        if (vy == 0) return (vx >= 0) ? 9'd0 : 9'd180;
        if (vx == 0) return (vy > 0) ? 9'd90 : 9'd270;
        if (ax == ay) begin
            if (vx > 0) return (vy > 0) ? 9'd45 : 9'd315;
            return (vy > 0) ? 9'd135 : 9'd225;
        end
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            phase = 32'h80000000;
        end
        m = (ax > ay) ? ax : ay;
        while (m < (64'sd1 <<< 40)) begin
            m = m * 2;
            vx = vx * 2;
            vy = vy * 2;
        end
        for (i = 0; i < N_ROT; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx = vx + dx;
                vy = vy - dy;
                phase = phase + ROT_ANGLE[i];
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                phase = phase - ROT_ANGLE[i];
            end
        end
        scaled = (64'(phase) * 64'd360) >> 32;
        return scaled[DEG_W-1:0];
    endfunction

    function automatic t_heading predict_heading(logic signed [CAL_W-1:0] rx,
                                                 logic signed [CAL_W-1:0] ry);
        t_heading h;
        longint   span_x, span_y, cx2, cy2;
        span_x = longint'(cal_max_x) - longint'(cal_min_x);
        span_y = longint'(cal_max_y) - longint'(cal_min_y);
        if (span_x <= 0 || span_y <= 0) begin
            h.deg = '0;
            h.cal_err = 1'b1;
            return h;
        end
        cx2 = 2 * longint'(rx) - (longint'(cal_min_x) + longint'(cal_max_x));
        cy2 = 2 * longint'(ry) - (longint'(cal_min_y) + longint'(cal_max_y));
        h.deg = vector_angle_deg(cx2 * span_y, cy2 * span_x);
        h.cal_err = 1'b0;
        return h;
    endfunction

    function automatic logic signed [CAL_W-1:0] sat16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[CAL_W-1:0];
    endfunction

    // one random coordinate around a calibration axis
    function automatic logic signed [CAL_W-1:0] pick_coord(logic signed [CAL_W-1:0] lo,
                                                           logic signed [CAL_W-1:0] hi);
        longint ctr, r, off;
        int     sel;
        ctr = (longint'(lo) + longint'(hi)) >>> 1;
        r = longint'(hi) - longint'(lo);
        r = ((r < 0) ? -r : r) / 2 + 4;
        sel = $urandom_range(0, 9);
        if (sel < 4) return CAL_W'($urandom);
        if (sel < 7) begin
            off = longint'($urandom_range(0, int'(2 * r))) - r;
            return sat16(ctr + off);
        end
        if (sel == 7) return sat16(ctr + longint'($urandom_range(0, 6)) - 3);
        if (sel == 8) begin
            case ($urandom_range(0, 4))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return -16'sd1;
                3: return 16'sd1;
                default: return 16'sd0;
            endcase
        end
        off = longint'($urandom_range(0, int'(2 * r - 8)));
        return sat16(longint'(lo) + off);
    endfunction

    task automatic push_sample(logic signed [CAL_W-1:0] x, logic signed [CAL_W-1:0] y);
        t_sample s;
        s.x = x;
        s.y = y;
        pending_samples.push_back(s);
    endtask

    task automatic queue_random(int n);
        int k;
        for (k = 0; k < n; k++) begin
            // sometimes tie X to the center of its calibration to land on exact angles
            if ($urandom_range(0, 15) == 0)
                push_sample(sat16((longint'(cal_min_x) + cal_max_x) >>> 1),
                            pick_coord(cal_min_y, cal_max_y));
            else
                push_sample(pick_coord(cal_min_x, cal_max_x), pick_coord(cal_min_y, cal_max_y));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_X: cal_min_x = val;
            REG_MAX_X: cal_max_x = val;
            REG_MIN_Y: cal_min_y = val;
            REG_MAX_Y: cal_max_y = val;
            default: ;
        endcase
    endtask

    task automatic set_cal(logic signed [CAL_W-1:0] mnx, logic signed [CAL_W-1:0] mxx,
                           logic signed [CAL_W-1:0] mny, logic signed [CAL_W-1:0] mxy);
        write_reg(REG_MIN_X, mnx);
        write_reg(REG_MAX_X, mxx);
        write_reg(REG_MIN_Y, mny);
        write_reg(REG_MAX_Y, mxy);
        // unmapped index, must be ignored
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CAL_W'($urandom));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_start || expected_headings.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin : drive
        t_sample nxt;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_headings.push_back(predict_heading(i_raw_x, i_raw_y));
            end
            if (!i_start || !o_busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_start <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    nxt = pending_samples.pop_front();
                    i_start <= 1'b1;
                    i_raw_x <= nxt.x;
                    i_raw_y <= nxt.y;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        t_heading want;
        if (i_rst_n && o_valid) begin
            if (expected_headings.size() == 0) begin
                $error("heading_deg: expected none, actual %0d", o_heading_deg);
                mismatch_cnt++;
            end else begin
                want = expected_headings.pop_front();
                if (o_heading_deg !== want.deg) begin
                    $error("heading_deg: expected %0d, actual %0d", want.deg, o_heading_deg);
                    mismatch_cnt++;
                end
                if (o_cal_error !== want.cal_err) begin
                    $error("cal_error: expected %0d, actual %0d", want.cal_err, o_cal_error);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[calibrated_compass_heading] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int                      k;
        logic signed [CAL_W-1:0] a, b, c, d, t;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset calibration, field extremes
        push_sample(16'sh8000, 16'sh8000);
        push_sample(16'sh7FFF, 16'sh7FFF);
        push_sample(16'sh8000, 16'sh7FFF);
        push_sample(16'sh7FFF, 16'sh8000);
        push_sample(16'sd0, 16'sd0);
        queue_random(120);
        wait_idle();

        // centered calibration: zero vector, axes, diagonals, wrap near a full turn
        set_cal(-16'sd100, 16'sd100, -16'sd50, 16'sd50);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd7, 16'sd0);
        push_sample(-16'sd7, 16'sd0);
        push_sample(16'sd0, 16'sd7);
        push_sample(16'sd0, -16'sd7);
        push_sample(16'sd10, 16'sd5);
        push_sample(-16'sd10, 16'sd5);
        push_sample(-16'sd10, -16'sd5);
        push_sample(16'sd10, -16'sd5);
        push_sample(16'sh7FFF, -16'sd1);
        push_sample(16'sh8000, -16'sd1);
        push_sample(16'sh8000, 16'sd1);
        queue_random(100);
        wait_idle();

        // widest span
        set_cal(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        push_sample(16'sh7FFF, 16'sh8000);
        push_sample(16'sh8000, 16'sh7FFF);
        queue_random(150);
        wait_idle();

        // bad X calibration: max equal to min
        set_cal(16'sd300, 16'sd300, -16'sd20, 16'sd40);
        push_sample(16'sd300, 16'sd10);
        push_sample(16'sh7FFF, 16'sh8000);
        queue_random(20);
        wait_idle();

        // bad Y calibration: max below min, full inversion
        set_cal(-16'sd5, 16'sd5, 16'sh7FFF, 16'sh8000);
        push_sample(16'sd0, 16'sd0);
        push_sample(16'sd3, 16'sh7FFF);
        queue_random(20);
        wait_idle();

        // narrowest spans
        set_cal(16'sd0, 16'sd1, -16'sd1, 16'sd0);
        queue_random(100);
        wait_idle();

        for (k = 0; k < 5; k++) begin
            a = CAL_W'($urandom);
            b = CAL_W'($urandom);
            c = CAL_W'($urandom);
            d = CAL_W'($urandom);
            if (a > b) begin t = a; a = b; b = t; end
            if (c > d) begin t = c; c = d; d = t; end
            if ($urandom_range(0, 5) == 0) begin t = c; c = d; d = t; end
            set_cal(a, b, c, d);
            queue_random(100);
            wait_idle();
        end

        wait_idle();
        repeat (N_ROT + 16) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[calibrated_compass_heading] OK");
        end else begin
            $display("[calibrated_compass_heading] ERROR");
        end
        $finish;
    end

endmodule
